/* src/msfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msfp_pkg: shared types and constants for the magic sync frame parser
// Header layout, configuration register indexes and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package msfp_pkg;

  // Header is magic (4), version (1), type (1), length (4).
  localparam int HDR_BYTES = 10;
  localparam int FILL_W    = 4;
  localparam int HUNT_KEEP = 3;
  localparam int VER_POS   = 4;
  localparam int TYPE_POS  = 5;
  localparam int LEN_POS   = 6;

  typedef logic [FILL_W-1:0] fill_t;
  typedef logic [7:0]        byte_t;
  typedef logic [31:0]       word_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_MAGIC       = 2'd0,
    CFG_VERSION     = 2'd1,
    CFG_MAX_PAYLOAD = 2'd2
  } cfg_idx_t;

  localparam word_t MAGIC_RST   = 32'd0;
  localparam byte_t VERSION_RST = 8'd1;
  localparam word_t MAX_PAY_RST = 32'd65536;

  // Commands from the controller; each is qualified by an accepted word
  // except scan_shift.
  typedef struct packed {
    logic push;        // Append the input byte at the fill position.
    logic slide;       // Drop the oldest byte and append the input byte.
    logic scan_shift;  // Drop the oldest byte without taking input.
    logic take_hdr;    // Latch type and length from a good header.
    logic emit_pay;    // Send a payload result and count it.
    logic emit_empty;  // Send the single result of a zero-length frame.
  } msfp_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic fill_lt_keep;   // Fewer than three bytes held while hunting.
    logic fill_hdr_last;  // The input byte completes the header.
    logic hunt_match;     // Three held bytes plus the input byte form the magic.
    logic hdr_ok;         // Version and length of the completed header are good.
    logic len_zero;       // Length of the completed header is zero.
    logic scan_match;     // The first four held bytes form the magic.
    logic scan_end;       // Only four bytes held during a rescan.
    logic pay_last;       // The next payload byte is the last one.
    logic out_full;       // The result register cannot take a word this cycle.
  } msfp_sts_t;

endpackage

/* src/magic_sync_frame_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magic_sync_frame_parser: byte stream parser for magic-prefixed frames
// Hunts for a big-endian magic word, checks a ten-byte header and passes
// the payload bytes on with the frame type and length.
//
// Input channel (in_valid/in_ready/in_byte) takes one stream byte per word.
// Result channel (out_valid/out_ready/out_*) gives one word per payload
// byte, with out_last_byte on the final one; a zero-length frame gives a
// single word with out_empty_frame and out_last_byte set.
// A result word appears in the cycle after the byte that causes it is taken.
// One byte is taken per cycle while hunting, collecting a header or
// passing payload, as long as the result register has room. A rejected
// header stops input while the buffered bytes are searched for a new
// magic word, one position per cycle, with a single window compare.
// The result register frees in the cycle it is taken, so a stalled
// receiver holds the input only while a result word waits.
// Configuration (cfg_we/cfg_index/cfg_wdata) is to be written only while idle,
// which the block does not enforce. Reset loads the default configuration and returns to the hunt.
// ----------------------------------------------------------------------------
module magic_sync_frame_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  msfp_pkg::byte_t  in_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output msfp_pkg::byte_t  out_payload_byte,
  output msfp_pkg::byte_t  out_type_byte,
  output msfp_pkg::word_t  out_frame_length,
  output logic             out_empty_frame,
  output logic             out_last_byte,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  msfp_pkg::word_t  cfg_wdata
);
  import msfp_pkg::*;

  msfp_cmd_t cmd;
  msfp_sts_t sts;

  // Phase controller.
  msfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Window, frame registers and result register.
  msfp_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_byte          (in_byte),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_payload_byte (out_payload_byte),
    .out_type_byte    (out_type_byte),
    .out_frame_length (out_frame_length),
    .out_empty_frame  (out_empty_frame),
    .out_last_byte    (out_last_byte)
  );

`ifndef NO_ASSERTIONS
  // Input is never taken while a result word is stuck in the register.
  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(out_valid && !out_ready))
    else $error("input taken while result register is blocked");

  // An empty-frame word is always the last one and carries zeros.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_frame) |->
      (out_last_byte && out_payload_byte == '0 && out_frame_length == '0))
    else $error("empty-frame word has bad fields");

  // A new result word only follows an accepted input byte.
  a_result_from_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result word without an accepted input byte");
`endif

endmodule

/* src/msfp_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msfp_dpath: datapath of the magic sync frame parser
// Holds the header window, the fill count, the frame registers, the
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module msfp_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  msfp_pkg::byte_t      in_byte,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  msfp_pkg::word_t      cfg_wdata,
  input  msfp_pkg::msfp_cmd_t  cmd,
  output msfp_pkg::msfp_sts_t  sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output msfp_pkg::byte_t      out_payload_byte,
  output msfp_pkg::byte_t      out_type_byte,
  output msfp_pkg::word_t      out_frame_length,
  output logic                 out_empty_frame,
  output logic                 out_last_byte
);
  import msfp_pkg::*;

  byte_t window_r [HDR_BYTES];
  byte_t win_shift [HDR_BYTES];
  fill_t fill_r;
  byte_t held_type_r;
  word_t held_len_r;
  word_t left_r;
  word_t magic_r;
  byte_t version_r;
  word_t max_pay_r;

  logic  out_valid_r;
  byte_t out_byte_r;
  byte_t out_type_r;
  word_t out_len_r;
  logic  out_empty_r;
  logic  out_last_r;

  word_t hunt_word;
  word_t scan_word;
  word_t hdr_len;

  // Candidate words for the magic and length compares.
  assign hunt_word = {window_r[0], window_r[1], window_r[2], in_byte};
  assign scan_word = {window_r[0], window_r[1], window_r[2], window_r[3]};
  assign hdr_len   = {window_r[LEN_POS], window_r[LEN_POS+1], window_r[LEN_POS+2], in_byte};

  // Window moved down by one byte.
  for (genvar g = 0; g < HDR_BYTES; g++) begin : g_shift
    if (g < HDR_BYTES - 1) begin : g_mid
      assign win_shift[g] = window_r[g+1];
    end else begin : g_top
      assign win_shift[g] = window_r[g];
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.fill_lt_keep  = fill_r < fill_t'(HUNT_KEEP);
    sts.fill_hdr_last = fill_r == fill_t'(HDR_BYTES - 1);
    sts.hunt_match    = hunt_word == magic_r;
    sts.hdr_ok        = (window_r[VER_POS] == version_r) && (hdr_len <= max_pay_r);
    sts.len_zero      = hdr_len == '0;
    sts.scan_match    = scan_word == magic_r;
    sts.scan_end      = fill_r == fill_t'(HUNT_KEEP + 1);
    sts.pay_last      = left_r <= 32'd1;
    sts.out_full      = out_valid_r && !out_ready;
  end

  // Header window contents; bytes past the fill count are don't-care.
  always_ff @(posedge clk) begin
    for (int k = 0; k < HDR_BYTES; k++) begin
      if (cmd.slide || cmd.scan_shift) begin
        window_r[k] <= win_shift[k];
      end
      if (cmd.slide && fill_r == fill_t'(k + 1)) begin
        window_r[k] <= in_byte;
      end
      if (cmd.push && fill_r == fill_t'(k)) begin
        window_r[k] <= in_byte;
      end
    end
  end

  // Fill count and bytes still to come in the payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      left_r <= '0;
    end else begin
      if (cmd.push) begin
        fill_r <= fill_r + fill_t'(1);
      end else if (cmd.scan_shift) begin
        fill_r <= fill_r - fill_t'(1);
      end else if (cmd.take_hdr) begin
        fill_r <= '0;
      end
      if (cmd.take_hdr) begin
        left_r <= hdr_len;
      end else if (cmd.emit_pay) begin
        left_r <= left_r - 32'd1;
      end
    end
  end

  // Frame type and length of a good header.
  always_ff @(posedge clk) begin
    if (cmd.take_hdr) begin
      held_type_r <= window_r[TYPE_POS];
      held_len_r  <= hdr_len;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= MAGIC_RST;
      version_r <= VERSION_RST;
      max_pay_r <= MAX_PAY_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MAGIC:       magic_r   <= cfg_wdata;
        CFG_VERSION:     version_r <= cfg_wdata[7:0];
        CFG_MAX_PAYLOAD: max_pay_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_pay || cmd.emit_empty) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (cmd.emit_pay) begin
      out_byte_r  <= in_byte;
      out_type_r  <= held_type_r;
      out_len_r   <= held_len_r;
      out_empty_r <= 1'b0;
      out_last_r  <= sts.pay_last;
    end else if (cmd.emit_empty) begin
      out_byte_r  <= '0;
      out_type_r  <= window_r[TYPE_POS];
      out_len_r   <= '0;
      out_empty_r <= 1'b1;
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_byte_r;
  assign out_type_byte    = out_type_r;
  assign out_frame_length = out_len_r;
  assign out_empty_frame  = out_empty_r;
  assign out_last_byte    = out_last_r;

endmodule

/* src/msfp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msfp_ctrl: controller of the magic sync frame parser
// Tracks the parse phase, owns the input handshake and issues one command
// set per cycle to the datapath.
// ----------------------------------------------------------------------------
module msfp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  msfp_pkg::msfp_sts_t  sts,
  output msfp_pkg::msfp_cmd_t  cmd
);
  import msfp_pkg::*;

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_HEADER,
    ST_PAYLOAD,
    ST_RESCAN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   fire;

  // Input is taken in every phase but the rescan, whenever the result
  // register has room.
  assign in_ready = (state_r != ST_RESCAN) && !sts.out_full;
  assign fire     = in_valid && in_ready;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_HUNT: begin
        if (fire) begin
          if (sts.fill_lt_keep) begin
            cmd.push = 1'b1;
          end else if (sts.hunt_match) begin
            cmd.push  = 1'b1;
            state_nxt = ST_HEADER;
          end else begin
            cmd.slide = 1'b1;
          end
        end
      end
      ST_HEADER: begin
        if (fire) begin
          if (!sts.fill_hdr_last) begin
            cmd.push = 1'b1;
          end else if (sts.hdr_ok) begin
            cmd.take_hdr = 1'b1;
            if (sts.len_zero) begin
              cmd.emit_empty = 1'b1;
              state_nxt      = ST_HUNT;
            end else begin
              state_nxt = ST_PAYLOAD;
            end
          end else begin
            // Bad header: drop its first byte and search the rest.
            cmd.slide = 1'b1;
            state_nxt = ST_RESCAN;
          end
        end
      end
      ST_PAYLOAD: begin
        if (fire) begin
          cmd.emit_pay = 1'b1;
          if (sts.pay_last) begin
            state_nxt = ST_HUNT;
          end
        end
      end
      ST_RESCAN: begin
        // One window position is checked per cycle.
        if (sts.scan_match) begin
          state_nxt = ST_HEADER;
        end else begin
          cmd.scan_shift = 1'b1;
          if (sts.scan_end) begin
            state_nxt = ST_HUNT;
          end
        end
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
  end

  // Phase register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
